// ===== hw/rtl/ocvgc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and curve tables for the ocv charge guard
package ocvgc_pkg;

   localparam int CURVE_POINTS = 12;
   localparam int SEG_W        = 4;
   localparam int SOC_W        = 14;
   localparam int LANE_LAT     = 7;

   localparam logic [15:0] CELL_MV_LOW  = 16'd2000;
   localparam logic [15:0] CELL_MV_HIGH = 16'd4600;
   localparam logic [SOC_W-1:0] SOC_FULL = 14'd10000;

   // floor(v / 100) = (v * RECIP_100) >> RECIP_100_SHIFT for v < 2**20
   localparam logic [20:0] RECIP_100       = 21'd1342178;
   localparam int          RECIP_100_SHIFT = 27;
   // floor(v / 100) for v < 2**16
   localparam logic [16:0] RECIP_PCT       = 17'd83887;
   localparam int          RECIP_PCT_SHIFT = 23;
   // segment reciprocals are scaled by 2**27
   localparam int          SEG_SHIFT       = 27;

   localparam logic [1:0] ACT_LEAVE = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_SET   = 2'd2;

   localparam logic [1:0] CSR_GUARD_ENABLE = 2'd0;
   localparam logic [1:0] CSR_RESISTANCE   = 2'd1;
   localparam logic [1:0] CSR_BAND         = 2'd2;
   localparam logic [1:0] CSR_CHEM_NMC     = 2'd3;

   typedef enum logic [1:0] {
      MODE_LEAVE,
      MODE_CLEAR,
      MODE_CHECK
   } mode_type;

   typedef struct packed {
      logic               link_alive;
      logic [15:0]        cell_min_mv;
      logic [15:0]        cell_max_mv;
      logic signed [15:0] pack_curr_da;
      logic [15:0]        soc_in;
   } req_type;

   typedef struct packed {
      logic [15:0] soc_out;
      logic [1:0]  event_action;
      logic [7:0]  drift_pct;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      mode_type    mode;
      logic [15:0] soc_in;
   } tag_type;

   function automatic logic [12:0] curve_mv(input logic [SEG_W-1:0] idx);
      logic [12:0] mv;
      case (idx)
         4'd0:    mv = 13'd3000;
         4'd1:    mv = 13'd3300;
         4'd2:    mv = 13'd3450;
         4'd3:    mv = 13'd3550;
         4'd4:    mv = 13'd3620;
         4'd5:    mv = 13'd3680;
         4'd6:    mv = 13'd3750;
         4'd7:    mv = 13'd3830;
         4'd8:    mv = 13'd3900;
         4'd9:    mv = 13'd3970;
         4'd10:   mv = 13'd4060;
         4'd11:   mv = 13'd4150;
         default: mv = 13'd4150;
      endcase
      return mv;
   endfunction

   // charge at the lower end of segment seg
   function automatic logic [SOC_W-1:0] seg_base_soc(input logic [SEG_W-1:0] seg);
      logic [SOC_W-1:0] s;
      case (seg)
         4'd1:    s = 14'd0;
         4'd2:    s = 14'd500;
         4'd3:    s = 14'd1000;
         4'd4:    s = 14'd2000;
         4'd5:    s = 14'd3000;
         4'd6:    s = 14'd4000;
         4'd7:    s = 14'd5000;
         4'd8:    s = 14'd6000;
         4'd9:    s = 14'd7000;
         4'd10:   s = 14'd8000;
         4'd11:   s = 14'd9000;
         default: s = 14'd0;
      endcase
      return s;
   endfunction

   function automatic logic [9:0] seg_ds(input logic [SEG_W-1:0] seg);
      logic [9:0] d;
      case (seg)
         4'd1, 4'd2: d = 10'd500;
         default:    d = 10'd1000;
      endcase
      return d;
   endfunction

   // ceil(2**27 / segment voltage span)
   function automatic logic [21:0] seg_recip(input logic [SEG_W-1:0] seg);
      logic [21:0] r;
      case (seg)
         4'd1:                     r = 22'd447393;
         4'd2:                     r = 22'd894785;
         4'd3:                     r = 22'd1342178;
         4'd4, 4'd6, 4'd8, 4'd9:   r = 22'd1917397;
         4'd5:                     r = 22'd2236963;
         4'd7:                     r = 22'd1677722;
         4'd10, 4'd11:             r = 22'd1491309;
         default:                  r = 22'd1342178;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/ocv_soc_guard_clamp_core.sv =====
`timescale 1ns / 1ps
// top level of the ocv based state-of-charge guard
//
//  channel   ports                              transfer
//  request   start, busy, req_data              start high while busy low
//  response  rsp_valid, rsp_data                one-cycle strobe, no back pressure
//  csr       csr_we, csr_index, csr_wdata       write when csr_we high
//
// one transaction may start every cycle while busy is low; each gives one response after
// the seven-stage voltage lanes (the ir multiply, two multiplies by reciprocals and the
// interpolation multiply) and the three-stage merge.
// busy is high only during reset and the cycle after it.
// the response cannot be stalled; it is shown for exactly one cycle.
module ocv_soc_guard_clamp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ocvgc_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output ocvgc_pkg::rsp_type   rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import ocvgc_pkg::*;

   localparam int         RSP_LAT          = 10;

   logic             guard_enable_ff, chem_nmc_ff, busy_ff;
   logic [15:0]      resistance_ff;
   logic [13:0]      band_ff;
   logic             accept_w, cells_ok_w;
   tag_type          tag_in;
   tag_type          tag_pipe_ff [LANE_LAT];
   logic [SOC_W-1:0] soc_lo_w, soc_hi_w;

   assign accept_w = start && !busy_ff;

   always_comb begin
      cells_ok_w = req_data.link_alive
                && req_data.cell_min_mv >= CELL_MV_LOW
                && req_data.cell_max_mv >= CELL_MV_LOW
                && req_data.cell_min_mv <= CELL_MV_HIGH
                && req_data.cell_max_mv <= CELL_MV_HIGH
                && req_data.cell_max_mv >= req_data.cell_min_mv;
      tag_in.valid  = accept_w;
      tag_in.soc_in = req_data.soc_in;
      if (!guard_enable_ff) begin
         tag_in.mode = MODE_CLEAR;
      end else if (!chem_nmc_ff || !cells_ok_w) begin
         tag_in.mode = MODE_LEAVE;
      end else begin
         tag_in.mode = MODE_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_enable_ff <= 1'b0;
         resistance_ff   <= 16'd5;
         band_ff         <= 14'd1000;
         chem_nmc_ff     <= 1'b0;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_GUARD_ENABLE: guard_enable_ff <= csr_wdata[0];
               CSR_RESISTANCE:   resistance_ff   <= csr_wdata;
               CSR_BAND:         band_ff         <= csr_wdata[13:0];
               CSR_CHEM_NMC:     chem_nmc_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            tag_pipe_ff[i].valid <= 1'b0;
         end
      end else begin
         tag_pipe_ff[0] <= tag_in;
         for (int i = 1; i < LANE_LAT; i++) begin
            tag_pipe_ff[i] <= tag_pipe_ff[i-1];
         end
      end
   end

   ocvgc_lane u_lane_min (
      .clock      (clock),
      .cell_mv    (req_data.cell_min_mv),
      .curr_da    (req_data.pack_curr_da),
      .resistance (resistance_ff),
      .soc        (soc_lo_w)
   );

   ocvgc_lane u_lane_max (
      .clock      (clock),
      .cell_mv    (req_data.cell_max_mv),
      .curr_da    (req_data.pack_curr_da),
      .resistance (resistance_ff),
      .soc        (soc_hi_w)
   );

   ocvgc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .soc_lo    (soc_lo_w),
      .soc_hi    (soc_hi_w),
      .band      (band_ff),
      .tag       (tag_pipe_ff[LANE_LAT-1]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign busy = busy_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept_w |-> ##RSP_LAT rsp_valid)
      else $error("response missing after accepted transaction");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept_w, RSP_LAT))
      else $error("response without a matching transaction");

   a_set_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_action == ACT_SET) |-> rsp_data.soc_out <= 16'(SOC_FULL))
      else $error("clamped charge out of range");

   a_dev_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_action != ACT_SET) |-> rsp_data.drift_pct == 8'd0)
      else $error("deviation set without clamp event");

endmodule

// ===== hw/rtl/ocvgc_lane.sv =====
`timescale 1ns / 1ps
// one cell voltage lane: ir correction and ocv curve interpolation
module ocvgc_lane (
   input  logic                          clock,
   input  logic [15:0]                   cell_mv,
   input  logic signed [15:0]            curr_da,
   input  logic [15:0]                   resistance,
   output logic [ocvgc_pkg::SOC_W-1:0]   soc
);
   import ocvgc_pkg::*;

   localparam logic signed [17:0] MV_FIRST = 18'sd3000;
   localparam logic signed [17:0] MV_LAST  = 18'sd4150;

   logic signed [32:0] prod_in, prod_ff;
   logic [15:0]        cell1_ff, cell2_ff, cell3_ff;

   logic [32:0]        abs_w;
   logic               neg2_ff, neg3_ff;
   logic [19:0]        mag_in, mag2_ff;

   logic [40:0]        qm_w;
   logic [13:0]        q3_ff;

   logic signed [17:0] corr_w, span_w;
   logic               lo_in, hi_in;
   logic [SEG_W-1:0]   seg_in;
   logic               lo4_ff, hi4_ff, lo5_ff, hi5_ff, lo6_ff, hi6_ff;
   logic [SEG_W-1:0]   seg4_ff, seg5_ff, seg6_ff;
   logic [8:0]         x4_ff;

   logic [17:0]        y_in, y5_ff;
   logic [39:0]        qs_w;
   logic [12:0]        q6_ff;
   logic [SOC_W-1:0]   soc_in, soc7_ff;

   assign prod_in = curr_da * $signed({1'b0, resistance});

   always_comb begin
      abs_w  = prod_ff[32] ? 33'(-prod_ff) : 33'(prod_ff);
      mag_in = (abs_w[32:20] != '0) ? '1 : abs_w[19:0];
   end

   assign qm_w = 41'(mag2_ff) * 41'(RECIP_100);

   always_comb begin
      corr_w = neg3_ff ? $signed({2'b00, cell3_ff}) + $signed({4'b0000, q3_ff})
                       : $signed({2'b00, cell3_ff}) - $signed({4'b0000, q3_ff});
      lo_in  = corr_w <= MV_FIRST;
      hi_in  = corr_w >= MV_LAST;
      seg_in = SEG_W'(CURVE_POINTS - 1);
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (corr_w <= $signed({5'b00000, curve_mv(SEG_W'(i))})) begin
            seg_in = SEG_W'(i);
         end
      end
      span_w = corr_w - $signed({5'b00000, curve_mv(seg_in - 4'd1)});
   end

   assign y_in = 18'(18'(x4_ff) * 18'(seg_ds(seg4_ff)));
   assign qs_w = 40'(y5_ff) * 40'(seg_recip(seg5_ff));

   always_comb begin
      if (lo6_ff) begin
         soc_in = '0;
      end else if (hi6_ff) begin
         soc_in = SOC_FULL;
      end else begin
         soc_in = SOC_W'(seg_base_soc(seg6_ff) + SOC_W'(q6_ff));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      cell1_ff <= cell_mv;
      neg2_ff  <= prod_ff[32];
      mag2_ff  <= mag_in;
      cell2_ff <= cell1_ff;
      neg3_ff  <= neg2_ff;
      q3_ff    <= qm_w[40:RECIP_100_SHIFT];
      cell3_ff <= cell2_ff;
      lo4_ff   <= lo_in;
      hi4_ff   <= hi_in;
      seg4_ff  <= seg_in;
      x4_ff    <= span_w[8:0];
      lo5_ff   <= lo4_ff;
      hi5_ff   <= hi4_ff;
      seg5_ff  <= seg4_ff;
      y5_ff    <= y_in;
      lo6_ff   <= lo5_ff;
      hi6_ff   <= hi5_ff;
      seg6_ff  <= seg5_ff;
      q6_ff    <= qs_w[39:SEG_SHIFT];
      soc7_ff  <= soc_in;
   end

   assign soc = soc7_ff;

endmodule

// ===== hw/rtl/ocvgc_merge.sv =====
`timescale 1ns / 1ps
// merge stage: charge bounds, clamp and deviation
module ocvgc_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ocvgc_pkg::SOC_W-1:0]   soc_lo,
   input  logic [ocvgc_pkg::SOC_W-1:0]   soc_hi,
   input  logic [13:0]                   band,
   input  ocvgc_pkg::tag_type            tag,
   output logic                          rsp_valid,
   output ocvgc_pkg::rsp_type            rsp_data
);
   import ocvgc_pkg::*;

   logic [14:0]      up_sum_w;
   logic [SOC_W-1:0] upper_in, lower_in, upper_ff, lower_ff;
   tag_type          tag1_ff, tag2_ff;

   logic [15:0]      clamp_in, clamp_ff, diff_in, diff_ff;
   logic             changed_ff;

   logic [32:0]      dev_w;
   logic [7:0]       dev_pct_w;
   rsp_type          rsp_in, rsp_ff;
   logic             valid_ff;

   always_comb begin
      up_sum_w = {1'b0, soc_lo} + {1'b0, band};
      upper_in = (up_sum_w > 15'(SOC_FULL)) ? SOC_FULL : up_sum_w[SOC_W-1:0];
      lower_in = (soc_hi >= band) ? soc_hi - band : '0;
      if (lower_in > upper_in) begin
         lower_in = upper_in;
      end
   end

   always_comb begin
      if (tag1_ff.soc_in > 16'(upper_ff)) begin
         clamp_in = 16'(upper_ff);
      end else if (tag1_ff.soc_in < 16'(lower_ff)) begin
         clamp_in = 16'(lower_ff);
      end else begin
         clamp_in = tag1_ff.soc_in;
      end
      diff_in = (tag1_ff.soc_in > clamp_in) ? tag1_ff.soc_in - clamp_in
                                            : clamp_in - tag1_ff.soc_in;
   end

   always_comb begin
      dev_w     = 33'(diff_ff) * 33'(RECIP_PCT);
      dev_pct_w = (dev_w[32:RECIP_PCT_SHIFT] > 10'd255) ? 8'd255
                                                       : dev_w[RECIP_PCT_SHIFT+7:RECIP_PCT_SHIFT];
      rsp_in.soc_out      = tag2_ff.soc_in;
      rsp_in.event_action = ACT_LEAVE;
      rsp_in.drift_pct    = '0;
      case (tag2_ff.mode)
         MODE_CLEAR: begin
            rsp_in.event_action = ACT_CLEAR;
         end
         MODE_CHECK: begin
            if (changed_ff) begin
               rsp_in.soc_out      = clamp_ff;
               rsp_in.event_action = ACT_SET;
               rsp_in.drift_pct    = dev_pct_w;
            end else begin
               rsp_in.event_action = ACT_CLEAR;
            end
         end
         default: begin
            rsp_in.event_action = ACT_LEAVE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      upper_ff   <= upper_in;
      lower_ff   <= lower_in;
      clamp_ff   <= clamp_in;
      diff_ff    <= diff_in;
      changed_ff <= clamp_in != tag1_ff.soc_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         tag1_ff  <= tag;
         tag2_ff  <= tag1_ff;
         valid_ff <= tag2_ff.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/ocv_soc_guard_clamp_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ocv based state-of-charge guard core
module ocv_soc_guard_clamp_core_test;
   import ocvgc_pkg::*;

   localparam int   OCV_MV  [0:11] = '{3000, 3300, 3450, 3550, 3620, 3680,
                                       3750, 3830, 3900, 3970, 4060, 4150};
   localparam int   OCV_SOC [0:11] = '{0, 500, 1000, 2000, 3000, 4000,
                                       5000, 6000, 7000, 8000, 9000, 10000};
   localparam int   SOC_MAX      = 10000;
   localparam int   PCT_DIV      = 100;
   localparam int   DEV_CAP      = 255;
   localparam int   WATCHDOG_MAX = 2000;
   localparam int   TAIL_CYCLES  = 20;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_data  = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   // shadow copies of the guard configuration
   logic        guard_on   = 1'b0;
   logic [15:0] resist_dmo = 16'd5;
   logic [13:0] band_pptt  = 14'd1000;
   logic        chem_nmc   = 1'b0;

   req_type status_backlog [$];
   rsp_type clamped_soc_due [$];
   int      issued_count   = 0;
   int      accepted_count = 0;
   int      fail_count     = 0;
   int      quiet_cycles   = 0;
   int      idle_pct       = 0;

   ocv_soc_guard_clamp_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int soc_at_mv(longint mv);
      int k;
      if (mv <= OCV_MV[0]) return 0;
      if (mv >= OCV_MV[11]) return SOC_MAX;
      for (k = 1; k < 12; k++) begin
         if (mv <= OCV_MV[k])
            return OCV_SOC[k-1] + int'(((mv - OCV_MV[k-1]) * (OCV_SOC[k] - OCV_SOC[k-1]))
                                       / (OCV_MV[k] - OCV_MV[k-1]));
      end
      return SOC_MAX;
   endfunction

   function automatic rsp_type clamp_soc(req_type r);
      rsp_type o;
      longint  drop;
      int      upper, lower, clamped, diff, dev, soc;
      soc            = int'(r.soc_in);
      o.soc_out      = r.soc_in;
      o.event_action = ACT_LEAVE;
      o.drift_pct    = 8'd0;
      if (!guard_on) begin
         o.event_action = ACT_CLEAR;
         return o;
      end
      if (!chem_nmc) return o;
      if (!r.link_alive || r.cell_min_mv < CELL_MV_LOW || r.cell_max_mv < CELL_MV_LOW ||
          r.cell_min_mv > CELL_MV_HIGH || r.cell_max_mv > CELL_MV_HIGH ||
          r.cell_max_mv < r.cell_min_mv)
         return o;
      drop  = (longint'($signed(r.pack_curr_da)) * longint'(resist_dmo)) / PCT_DIV;
      upper = soc_at_mv(longint'(r.cell_min_mv) - drop) + int'(band_pptt);
      lower = soc_at_mv(longint'(r.cell_max_mv) - drop) - int'(band_pptt);
      if (upper > SOC_MAX) upper = SOC_MAX;
      if (lower < 0) lower = 0;
      if (lower > upper) lower = upper;
      clamped = soc;
      if (clamped > upper) clamped = upper;
      if (clamped < lower) clamped = lower;
      if (clamped == soc) begin
         o.event_action = ACT_CLEAR;
         return o;
      end
      diff = (soc > clamped) ? soc - clamped : clamped - soc;
      dev  = diff / PCT_DIV;
      if (dev > DEV_CAP) dev = DEV_CAP;
      o.soc_out      = 16'(clamped);
      o.event_action = ACT_SET;
      o.drift_pct    = 8'(dev);
      return o;
   endfunction

   function automatic req_type make_status(logic alive, int cmin, int cmax, int cur,
                                           int soc);
      req_type r;
      r.link_alive   = alive;
      r.cell_min_mv  = 16'(cmin);
      r.cell_max_mv  = 16'(cmax);
      r.pack_curr_da = 16'(cur);
      r.soc_in       = 16'(soc);
      return r;
   endfunction

   function automatic req_type random_status();
      req_type     r;
      logic [95:0] raw;
      int          v1, v2, t;
      if ($urandom_range(99) < 15) begin
         raw = {$urandom, $urandom, $urandom};
         r   = raw[$bits(req_type)-1:0];
         return r;
      end
      if ($urandom_range(99) < 80) begin
         v1 = $urandom_range(4250, 2900);
         v2 = $urandom_range(4250, 2900);
      end else begin
         v1 = $urandom_range(4600, 2000);
         v2 = $urandom_range(4600, 2000);
      end
      if ($urandom_range(9) == 0) v2 = v1;
      if (v1 > v2) begin
         t  = v1;
         v1 = v2;
         v2 = t;
      end
      r.link_alive   = 1'b1;
      r.cell_min_mv  = 16'(v1);
      r.cell_max_mv  = 16'(v2);
      r.pack_curr_da = ($urandom_range(1) == 0) ? 16'($urandom_range(2000) - 1000)
                                                : 16'($urandom);
      r.soc_in       = ($urandom_range(99) < 80) ? 16'($urandom_range(SOC_MAX))
                                                 : 16'($urandom);
      return r;
   endfunction

   // driver: one transaction held until accepted
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && accepted_count != issued_count) begin
      end else if (status_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
         start        <= 1'b1;
         req_data     <= status_backlog.pop_front();
         issued_count <= issued_count + 1;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on accept, check on response strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy) begin
         clamped_soc_due.push_back(clamp_soc(req_data));
         accepted_count <= accepted_count + 1;
      end
      if (!reset && rsp_valid === 1'b1) begin
         if (clamped_soc_due.size() == 0) begin
            $error("unexpected response transaction: soc_out %0d", rsp_data.soc_out);
            fail_count = fail_count + 1;
         end else begin
            want = clamped_soc_due.pop_front();
            if (rsp_data.soc_out !== want.soc_out) begin
               $error("soc_out mismatch: expected %0d, actual %0d",
                      want.soc_out, rsp_data.soc_out);
               fail_count = fail_count + 1;
            end
            if (rsp_data.event_action !== want.event_action) begin
               $error("event_action mismatch: expected %0d, actual %0d",
                      want.event_action, rsp_data.event_action);
               fail_count = fail_count + 1;
            end
            if (rsp_data.drift_pct !== want.drift_pct) begin
               $error("drift_pct mismatch: expected %0d, actual %0d",
                      want.drift_pct, rsp_data.drift_pct);
               fail_count = fail_count + 1;
            end
         end
      end
      if ((start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drain_guard();
      while (status_backlog.size() != 0 || accepted_count != issued_count ||
             clamped_soc_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic apply_guard_config(logic [15:0] en, logic [15:0] res, logic [15:0] band,
                                     logic [15:0] nmc);
      logic [1:0]  idx [4];
      logic [15:0] val [4];
      int          k;
      idx = '{CSR_GUARD_ENABLE, CSR_RESISTANCE, CSR_BAND, CSR_CHEM_NMC};
      val = '{en, res, band, nmc};
      for (k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(negedge clock);
      end
      csr_we     <= 1'b0;
      guard_on   = en[0];
      resist_dmo = res;
      band_pptt  = band[13:0];
      chem_nmc   = nmc[0];
   endtask

   task automatic run_random(int count, int idle);
      int k;
      idle_pct = idle;
      for (k = 0; k < count; k++) status_backlog.push_back(random_status());
      drain_guard();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: disabled, then not nmc
      idle_pct = 0;
      status_backlog.push_back(make_status(1, 3500, 3600, 0, 5000));
      drain_guard();
      apply_guard_config(16'd1, 16'd5, 16'd1000, 16'd0);
      status_backlog.push_back(make_status(1, 3500, 3600, 0, 5000));
      drain_guard();

      // invalid cell data, curve ends, clamping both ways
      apply_guard_config(16'hFFFF, 16'd5, 16'd1000, 16'hFFFF);
      status_backlog.push_back(make_status(0, 3500, 3600, 0, 5000));
      status_backlog.push_back(make_status(1, 1999, 3600, 0, 5000));
      status_backlog.push_back(make_status(1, 3500, 4601, 0, 5000));
      status_backlog.push_back(make_status(1, 3700, 3600, 0, 5000));
      status_backlog.push_back(make_status(1, 2000, 4600, 0, 5000));
      status_backlog.push_back(make_status(1, 3000, 4150, 0, 0));
      status_backlog.push_back(make_status(1, 3375, 3375, 0, 65535));
      status_backlog.push_back(make_status(1, 3375, 3375, 0, 0));
      status_backlog.push_back(make_status(1, 3600, 3650, 0, 2500));
      status_backlog.push_back(make_status(1, 3600, 3650, -32768, 2500));
      status_backlog.push_back(make_status(1, 3600, 3650, 32767, 10000));
      status_backlog.push_back(make_status(1, 4150, 4150, 100, 9999));
      drain_guard();

      // band above full scale, largest resistance
      apply_guard_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
      status_backlog.push_back(make_status(1, 3600, 3650, 32767, 0));
      status_backlog.push_back(make_status(1, 3600, 3650, -32768, 65535));
      status_backlog.push_back(make_status(1, 2000, 2000, -1, 10000));
      drain_guard();

      // zero band and resistance
      apply_guard_config(16'd1, 16'd0, 16'd0, 16'd1);
      status_backlog.push_back(make_status(1, 3450, 3450, -32768, 1000));
      status_backlog.push_back(make_status(1, 3450, 3450, 0, 1001));
      status_backlog.push_back(make_status(1, 3551, 3619, 32767, 0));
      status_backlog.push_back(make_status(1, 4000, 4100, 0, 8000));
      drain_guard();

      // random phases
      apply_guard_config(16'd1, 16'd5, 16'd1000, 16'd1);
      run_random(170, 34);
      apply_guard_config(16'd1, 16'd0, 16'd0, 16'd1);
      run_random(150, 34);
      apply_guard_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
      run_random(150, 61);
      apply_guard_config(16'd1, 16'($urandom_range(2000, 1)), 16'($urandom_range(SOC_MAX)),
                         16'd1);
      run_random(170, 61);
      apply_guard_config(16'hFFFE, 16'($urandom), 16'($urandom_range(SOC_MAX)), 16'd1);
      run_random(60, 0);
      apply_guard_config(16'd1, 16'($urandom_range(300)), 16'($urandom_range(3000)), 16'd1);
      run_random(190, 0);
      apply_guard_config(16'd1, 16'd5, 16'd1000, 16'hFFFE);
      run_random(60, 0);

      drain_guard();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ocvgc_pkg.sv
hw/rtl/ocvgc_lane.sv
hw/rtl/ocvgc_merge.sv
hw/rtl/ocv_soc_guard_clamp_core.sv
tb/sv/ocv_soc_guard_clamp_core_test.sv
